[design/vnos_pkg.sv]
`default_nettype none

package vnos_pkg;

    // default sizes
    localparam int TABLE_SIZE_DEF  = 256;
    localparam int MAX_OCTAVES_DEF = 16;

    // input operation codes
    localparam logic [1:0] OP_WR_PERM  = 2'd0;
    localparam logic [1:0] OP_WR_VALUE = 2'd1;
    localparam logic [1:0] OP_SAMPLE   = 2'd2;

    // configuration register indexes
    localparam int         CFG_IDX_W    = 2;
    localparam logic [1:0] CFG_PERSIST  = 2'd0;
    localparam logic [1:0] CFG_LACUNAR  = 2'd1;
    localparam logic [1:0] CFG_OCTAVES  = 2'd2;

    // configuration reset values
    localparam logic [15:0] PERSIST_RST = 16'd32768;
    localparam logic [15:0] LACUNAR_RST = 16'd8192;
    localparam logic [4:0]  OCTAVES_RST = 5'd8;

    // accumulator widths: octave sum (up to 32 octaves) and normalized numerator
    localparam int SUM_W = 39;
    localparam int NUM_W = 57;

    // sqrt(2) in Q1.16 and the quotient clamp
    localparam logic [17:0]      SQRT2_Q16 = 18'd92682;
    localparam logic [NUM_W-1:0] Q_LIMIT   = NUM_W'(1) << 40;

endpackage

`default_nettype wire

[design/value_noise_octave_sampler_unit.sv]
// channel | direction | handshake               | payload
// in      | input     | i_in_valid / o_in_stall | operation, table_index, perm_entry,
//         |           |                         | value_entry, x_coord, z_coord
// out     | output    | o_out_valid / i_out_stall | height
// cfg     | input     | i_cfg_we                | i_cfg_idx, i_cfg_data
//
// a table write does not make the input stall; a sample holds the input stalled while the
// sequencer runs: the octave steps in the shared multiplier sequence, repeated for the
// clamped octave count, then the numerator, the bit-serial divider, the final scale and the
// load of the output register
// reset is synchronous and active low; it clears control and configuration, not the tables
// a result waiting in the output register does not block table writes; the next sample
// finishes only once that register is free
`default_nettype none

module value_noise_octave_sampler_unit #(
    parameter int TABLE_SIZE  = vnos_pkg::TABLE_SIZE_DEF,
    parameter int MAX_OCTAVES = vnos_pkg::MAX_OCTAVES_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic [1:0]                    i_in_operation,
    input  wire logic [7:0]                    i_in_table_index,
    input  wire logic [7:0]                    i_in_perm_entry,
    input  wire logic signed [15:0]            i_in_value_entry,
    input  wire logic [23:0]                   i_in_x_coord,
    input  wire logic [23:0]                   i_in_z_coord,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic [15:0]                        o_height,
    input  wire logic                          i_cfg_we,
    input  wire logic [vnos_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [15:0]                   i_cfg_data
);

    localparam int AW = $clog2(TABLE_SIZE);
    localparam int OW = $clog2(MAX_OCTAVES + 1);
    localparam int SW = vnos_pkg::SUM_W;
    localparam int DW = vnos_pkg::NUM_W;
    localparam int CW = $clog2(DW);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_OCT  = 3'd1;
    localparam logic [2:0] ST_NUM  = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_SCL  = 3'd4;
    localparam logic [2:0] ST_DONE = 3'd5;

    // reduce an 8 bit entry to a table address
    function automatic logic [AW-1:0] to_idx(input logic [7:0] v);
        logic [AW+7:0] w;
        w = {{AW{1'b0}}, v};
        return w[AW-1:0];
    endfunction

    // smoothstep weight from t^2 and t^3
    function automatic logic [15:0] smooth(input logic [31:0] t2,
                                           input logic signed [50:0] t3);
        logic [50:0] up;
        logic [50:0] dn;
        logic [50:0] df;
        up = ({19'b0, t2} << 17) + ({19'b0, t2} << 16);
        dn = {t3[49:0], 1'b0};
        df = up - dn;
        return df[47:32];
    endfunction

    // a + floor(product / 2^16)
    function automatic logic signed [15:0] blend(input logic signed [15:0] a,
                                                 input logic signed [50:0] p);
        logic [16:0] s;
        s = {a[15], a} + p[32:16];
        return s[15:0];
    endfunction

    logic [2:0]              r_state;
    logic [4:0]              r_step;
    logic [15:0]             r_pers;
    logic [15:0]             r_lac;
    logic [4:0]              r_oct_cfg;
    logic [23:0]             r_x;
    logic [23:0]             r_z;
    logic [OW-1:0]           r_n;
    logic [OW-1:0]           r_oct;
    logic [AW-1:0]           r_i;
    logic [AW-1:0]           r_j;
    logic [31:0]             r_t2;
    logic [15:0]             r_sx;
    logic [15:0]             r_sz;
    logic signed [15:0]      r_ca;
    logic signed [15:0]      r_cb;
    logic signed [15:0]      r_cc;
    logic signed [15:0]      r_cd;
    logic signed [15:0]      r_v0;
    logic signed [15:0]      r_v1;
    logic [16:0]             r_amp;
    logic signed [SW-1:0]    r_sum;
    logic signed [DW-1:0]    r_acc;
    logic                    r_neg;
    logic [DW-1:0]           r_quo;
    logic [16:0]             r_rem;
    logic [16:0]             r_den;
    logic [CW-1:0]           r_cnt;
    logic signed [41:0]      r_q;
    logic [15:0]             r_hres;
    logic                    r_out_valid;
    logic [15:0]             r_height;
    logic signed [50:0]      r_prod;
    logic [7:0]              r_pdata;
    logic signed [15:0]      r_vdata;
    logic [2:0]              n_state;

    logic [7:0]              perm_mem  [TABLE_SIZE];
    logic [15:0]             value_mem [TABLE_SIZE];

    logic                    in_xfer;
    logic                    out_free;
    logic [AW-1:0]           dx;
    logic [AW-1:0]           dz;
    logic [AW-1:0]           paddr;
    logic [AW-1:0]           vaddr;
    logic signed [32:0]      mul_a;
    logic signed [17:0]      mul_b;
    logic [16:0]             dpers;
    logic signed [16:0]      diff;
    logic signed [DW-1:0]    num;
    logic [17:0]             shv;
    logic [18:0]             trial;
    logic [40:0]             qmag;
    logic signed [63:0]      tot;
    logic signed [32:0]      hs;
    logic [OW-1:0]           n_clamp;

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_height    = r_height;
    assign in_xfer     = i_in_valid && !o_in_stall;
    assign out_free    = !r_out_valid || !i_out_stall;

    assign dx    = to_idx(r_x[23:16]);
    assign dz    = to_idx(r_z[23:16]);
    assign dpers = 17'h10000 - {1'b0, r_pers};

    // clamp the configured octave count
    always_comb begin
        if (r_oct_cfg == 5'd0) begin
            n_clamp = OW'(1);
        end else if (32'(r_oct_cfg) > 32'(MAX_OCTAVES)) begin
            n_clamp = OW'(MAX_OCTAVES);
        end else begin
            n_clamp = OW'(r_oct_cfg);
        end
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pers    <= vnos_pkg::PERSIST_RST;
            r_lac     <= vnos_pkg::LACUNAR_RST;
            r_oct_cfg <= vnos_pkg::OCTAVES_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                vnos_pkg::CFG_PERSIST: r_pers    <= i_cfg_data;
                vnos_pkg::CFG_LACUNAR: r_lac     <= i_cfg_data;
                vnos_pkg::CFG_OCTAVES: r_oct_cfg <= i_cfg_data[4:0];
                default: ;
            endcase
        end
    end

    // table read addresses for the corner lookups
    always_comb begin
        paddr = '0;
        vaddr = to_idx(r_pdata);
        if (r_state == ST_OCT) begin
            case (r_step)
                5'd0:    paddr = dx;
                5'd1:    paddr = dx + 1'b1;
                5'd2:    paddr = r_i + dz;
                5'd3:    paddr = r_j + dz;
                5'd4:    paddr = r_i + dz + 1'b1;
                5'd5:    paddr = r_j + dz + 1'b1;
                default: paddr = '0;
            endcase
        end
    end

    // table memories, registered reads
    always_ff @(posedge i_clk) begin
        if (in_xfer && i_in_operation == vnos_pkg::OP_WR_PERM) begin
            perm_mem[to_idx(i_in_table_index)] <= i_in_perm_entry;
        end
        if (in_xfer && i_in_operation == vnos_pkg::OP_WR_VALUE) begin
            value_mem[to_idx(i_in_table_index)] <= i_in_value_entry;
        end
        r_pdata <= perm_mem[paddr];
        r_vdata <= value_mem[vaddr];
    end

    // operand select for the shared multiplier
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        diff  = '0;
        unique case (r_state)
            ST_OCT: begin
                case (r_step)
                    5'd0: begin
                        mul_a = {17'b0, r_x[15:0]};
                        mul_b = {2'b0, r_x[15:0]};
                    end
                    5'd1: begin
                        mul_a = {1'b0, r_prod[31:0]};
                        mul_b = {2'b0, r_x[15:0]};
                    end
                    5'd2: begin
                        mul_a = {17'b0, r_z[15:0]};
                        mul_b = {2'b0, r_z[15:0]};
                    end
                    5'd3: begin
                        mul_a = {1'b0, r_prod[31:0]};
                        mul_b = {2'b0, r_z[15:0]};
                    end
                    5'd6: begin
                        diff  = {r_cb[15], r_cb} - {r_ca[15], r_ca};
                        mul_a = {{16{diff[16]}}, diff};
                        mul_b = {2'b0, r_sx};
                    end
                    5'd8: begin
                        diff  = {r_cd[15], r_cd} - {r_cc[15], r_cc};
                        mul_a = {{16{diff[16]}}, diff};
                        mul_b = {2'b0, r_sx};
                    end
                    5'd10: begin
                        diff  = {r_v1[15], r_v1} - {r_v0[15], r_v0};
                        mul_a = {{16{diff[16]}}, diff};
                        mul_b = {2'b0, r_sz};
                    end
                    5'd12: begin
                        mul_a = {16'b0, r_amp};
                        mul_b = {{2{r_v0[15]}}, r_v0};
                    end
                    5'd13: begin
                        mul_a = {16'b0, r_amp};
                        mul_b = {2'b0, r_pers};
                    end
                    5'd14: begin
                        mul_a = {9'b0, r_x};
                        mul_b = {2'b0, r_lac};
                    end
                    5'd15: begin
                        mul_a = {9'b0, r_z};
                        mul_b = {2'b0, r_lac};
                    end
                    default: ;
                endcase
            end
            ST_NUM: begin
                mul_b = {1'b0, dpers};
                if (r_step == 5'd0) begin
                    mul_a = {{13{r_sum[SW-1]}}, r_sum[SW-1:19]};
                end else begin
                    mul_a = {14'b0, r_sum[18:0]};
                end
            end
            ST_SCL: begin
                mul_b = vnos_pkg::SQRT2_Q16;
                if (r_step == 5'd1) begin
                    mul_a = {9'b0, r_q[23:0]};
                end else begin
                    mul_a = {{15{r_q[41]}}, r_q[41:24]};
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
    end

    // numerator, divider trial and final scale
    assign num   = r_acc + {{(DW-51){r_prod[50]}}, r_prod};
    assign shv   = {r_rem, r_quo[DW-1]};
    assign trial = {1'b0, shv} - {2'b0, r_den};
    assign qmag  = (r_quo > vnos_pkg::Q_LIMIT) ? vnos_pkg::Q_LIMIT[40:0] : r_quo[40:0];
    assign tot   = {{(64-DW){r_acc[DW-1]}}, r_acc}
                 + ({{13{r_prod[50]}}, r_prod} <<< 24)
                 + (64'sd1 <<< 31);
    assign hs    = {tot[63], tot[63:32]} + 33'sd32768;

    // sequencer state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_xfer && i_in_operation == vnos_pkg::OP_SAMPLE) begin
                    n_state = ST_OCT;
                end
            end
            ST_OCT: begin
                if (r_step == 5'd16 && r_oct == r_n - 1'b1) begin
                    n_state = ST_NUM;
                end
            end
            ST_NUM: begin
                if (r_step == 5'd2) begin
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                if (r_cnt == CW'(DW - 1)) begin
                    n_state = ST_SCL;
                end
            end
            ST_SCL: begin
                if (r_step == 5'd3) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            if (n_state != r_state || (r_state == ST_OCT && r_step == 5'd16)) begin
                r_step <= '0;
            end else begin
                r_step <= r_step + 1'b1;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                r_x   <= i_in_x_coord;
                r_z   <= i_in_z_coord;
                r_amp <= 17'h10000;
                r_sum <= '0;
                r_oct <= '0;
                r_n   <= n_clamp;
            end
            ST_OCT: begin
                case (r_step)
                    5'd1: begin
                        r_i  <= to_idx(r_pdata);
                        r_t2 <= r_prod[31:0];
                    end
                    5'd2: begin
                        r_j  <= to_idx(r_pdata);
                        r_sx <= smooth(r_t2, r_prod);
                    end
                    5'd3: r_t2 <= r_prod[31:0];
                    5'd4: begin
                        r_sz <= smooth(r_t2, r_prod);
                        r_ca <= r_vdata;
                    end
                    5'd5:  r_cb <= r_vdata;
                    5'd6:  r_cc <= r_vdata;
                    5'd7: begin
                        r_cd <= r_vdata;
                        r_v0 <= blend(r_ca, r_prod);
                    end
                    5'd9:  r_v1 <= blend(r_cc, r_prod);
                    5'd11: r_v0 <= blend(r_v0, r_prod);
                    5'd13: r_sum <= r_sum + {{(SW-34){r_prod[33]}}, r_prod[33:0]};
                    5'd14: r_amp <= r_prod[32:16];
                    5'd15: r_x <= r_prod[35:12];
                    5'd16: begin
                        r_z   <= r_prod[35:12];
                        r_oct <= r_oct + 1'b1;
                    end
                    default: ;
                endcase
            end
            ST_NUM: begin
                if (r_step == 5'd1) begin
                    r_acc <= {{(DW-51){r_prod[50]}}, r_prod} <<< 19;
                end
                if (r_step == 5'd2) begin
                    r_neg <= num[DW-1];
                    r_quo <= num[DW-1] ? DW'(-num) : DW'(num);
                    r_rem <= '0;
                    r_den <= 17'h10000 - r_amp;
                    r_cnt <= '0;
                end
            end
            ST_DIV: begin
                // restoring division, one quotient bit per cycle
                if (!trial[18]) begin
                    r_rem <= trial[16:0];
                    r_quo <= {r_quo[DW-2:0], 1'b1};
                end else begin
                    r_rem <= shv[16:0];
                    r_quo <= {r_quo[DW-2:0], 1'b0};
                end
                r_cnt <= r_cnt + 1'b1;
            end
            ST_SCL: begin
                case (r_step)
                    5'd0: r_q <= r_neg ? -$signed({1'b0, qmag}) : $signed({1'b0, qmag});
                    5'd2: r_acc <= {{(DW-51){r_prod[50]}}, r_prod};
                    5'd3: begin
                        if (hs < 0) begin
                            r_hres <= 16'd0;
                        end else if (hs > 33'sd65535) begin
                            r_hres <= 16'hFFFF;
                        end else begin
                            r_hres <= hs[15:0];
                        end
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == ST_DONE && out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_DONE && out_free) begin
            r_height <= r_hres;
        end
    end

endmodule

`default_nettype wire

[design/vnos_checker.sv]
`default_nettype none

module vnos_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        o_in_stall,
    input wire logic [1:0]  i_in_operation,
    input wire logic        o_out_valid,
    input wire logic        i_out_stall,
    input wire logic [15:0] o_height
);

    // a held result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    // a sample transfer makes the block busy next cycle
    a_sample_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && i_in_operation == vnos_pkg::OP_SAMPLE |=> o_in_stall)
        else $error("sample accepted without going busy");

    // table writes and unused codes never make the block busy
    a_write_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && i_in_operation != vnos_pkg::OP_SAMPLE |=> !o_in_stall)
        else $error("write transfer made the block busy");

    // reset leaves no result and an open input
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("state not cleared by reset");

    // a held result keeps its value
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_height))
        else $error("height changed while stalled");

endmodule

bind value_noise_octave_sampler_unit vnos_checker u_vnos_checker (.*);

`default_nettype wire

[bench/tb_value_noise_octave_sampler_unit.sv]
`timescale 1ns / 100ps

module tb_value_noise_octave_sampler_unit;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_stall;
    logic [1:0]            i_in_operation;
    logic [7:0]            i_in_table_index;
    logic [7:0]            i_in_perm_entry;
    logic signed [15:0]    i_in_value_entry;
    logic [23:0]           i_in_x_coord;
    logic [23:0]           i_in_z_coord;
    logic                  o_out_valid;
    logic                  i_out_stall;
    logic [15:0]           o_height;
    logic                  i_cfg_we;
    logic [vnos_pkg::CFG_IDX_W-1:0] i_cfg_idx;
    logic [15:0]           i_cfg_data;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int         DRAIN_CYCLES = 400;
    localparam int         HOLD_CYCLES  = 1500;

    value_noise_octave_sampler_unit uut (.*);

    // clock
    initial i_clk = 1'b0;
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // mirrored block state
    logic [7:0]         perm_mirror [256];
    logic signed [15:0] height_mirror [256];
    logic [15:0]        persist_cfg;
    logic [15:0]        lacunar_cfg;
    logic [4:0]         octaves_cfg;

    logic [15:0] expected_heights [$];
    int          fail_count;
    int          send_idle_pct;
    int          recv_idle_pct;
    int          hold_token;
    int          hold_seen;
    int          hold_left;

    function automatic longint smooth_wt(logic [15:0] t);
        longint tt;
        tt = t;
        return (((3 * tt * tt) << 16) - (2 * tt * tt * tt)) >>> 32;
    endfunction

    function automatic longint blend(longint s, longint a, longint b);
        return a + (((b - a) * s) >>> 16);
    endfunction

    function automatic longint corner_height(int h, int dz);
        longint v;
        v = height_mirror[perm_mirror[(h + dz) & 255]];
        return v;
    endfunction

    function automatic longint octave_noise(longint x, longint z);
        int     dx, dz, i, j;
        longint sx, sz, v0, v1;
        dx = int'((x >> 16) & 255);
        dz = int'((z >> 16) & 255);
        sx = smooth_wt(x[15:0]);
        sz = smooth_wt(z[15:0]);
        i  = perm_mirror[dx];
        j  = perm_mirror[(dx + 1) & 255];
        v0 = blend(sx, corner_height(i, dz), corner_height(j, dz));
        v1 = blend(sx, corner_height(i, dz + 1), corner_height(j, dz + 1));
        return blend(sz, v0, v1);
    endfunction

    function automatic logic [15:0] predict_height(logic [23:0] x0, logic [23:0] z0);
        longint x, z, amp, sum, q, h, pers, lac;
        int     n;
        x    = x0;
        z    = z0;
        pers = persist_cfg;
        lac  = lacunar_cfg;
        n    = octaves_cfg;
        if (n < 1) n = 1;
        if (n > 16) n = 16;
        amp = 65536;
        sum = 0;
        for (int k = 0; k < n; k++) begin
            sum += amp * octave_noise(x, z);
            amp = (amp * pers) >> 16;
            x   = ((x * lac) >> 12) & 64'hFFFFFF;
            z   = ((z * lac) >> 12) & 64'hFFFFFF;
        end
        q = (sum * (65536 - pers)) / (65536 - amp);
        if (q > (64'sd1 <<< 40)) q = 64'sd1 <<< 40;
        if (q < -(64'sd1 <<< 40)) q = -(64'sd1 <<< 40);
        h = 32768 + ((q * 92682 + (64'sd1 <<< 31)) >>> 32);
        if (h < 0) h = 0;
        if (h > 65535) h = 65535;
        return h[15:0];
    endfunction

    // receiver: random stall, or a long hold-off on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            hold_left   <= 0;
            hold_seen   <= 0;
        end else if (hold_token != hold_seen) begin
            hold_seen   <= hold_token;
            hold_left   <= HOLD_CYCLES;
            i_out_stall <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left   <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // check each result transfer against the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_heights.size() == 0) begin
                $error("height: unexpected result %0d", o_height);
                fail_count++;
            end else begin
                logic [15:0] exp_h;
                exp_h = expected_heights.pop_front();
                if (o_height !== exp_h) begin
                    $error("height: expected %0d actual %0d", exp_h, o_height);
                    fail_count++;
                end
            end
        end
    end

    // one input transfer; called and returns at a rising edge
    task automatic send_item(logic [1:0] op, logic [7:0] idx, logic [7:0] pe,
                             logic [15:0] ve, logic [23:0] x, logic [23:0] z);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_in_operation   <= op;
        i_in_table_index <= idx;
        i_in_perm_entry  <= pe;
        i_in_value_entry <= ve;
        i_in_x_coord     <= x;
        i_in_z_coord     <= z;
        do @(posedge i_clk); while (o_in_stall);
        case (op)
            vnos_pkg::OP_WR_PERM:  perm_mirror[idx] = pe;
            vnos_pkg::OP_WR_VALUE: height_mirror[idx] = ve;
            vnos_pkg::OP_SAMPLE:   expected_heights.push_back(predict_height(x, z));
            default: ;
        endcase
    endtask

    task automatic send_sample(logic [23:0] x, logic [23:0] z);
        send_item(vnos_pkg::OP_SAMPLE, 8'($urandom), 8'($urandom), 16'($urandom), x, z);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (expected_heights.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_cfg(logic [vnos_pkg::CFG_IDX_W-1:0] idx, logic [15:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        case (idx)
            vnos_pkg::CFG_PERSIST: persist_cfg = data;
            vnos_pkg::CFG_LACUNAR: lacunar_cfg = data;
            vnos_pkg::CFG_OCTAVES: octaves_cfg = data[4:0];
            default: ;
        endcase
    endtask

    task automatic set_config(logic [15:0] p, logic [15:0] l, logic [4:0] n);
        drain();
        write_cfg(vnos_pkg::CFG_PERSIST, p);
        write_cfg(vnos_pkg::CFG_LACUNAR, l);
        write_cfg(vnos_pkg::CFG_OCTAVES, {11'd0, n});
    endtask

    // fill both tables so no later read hits an unwritten entry
    task automatic test_table_load();
        for (int k = 0; k < 256; k++)
            send_item(vnos_pkg::OP_WR_PERM, k[7:0], 8'($urandom), 16'($urandom),
                      24'($urandom), 24'($urandom));
        for (int k = 0; k < 256; k++) begin
            logic [15:0] v;
            v = 16'($urandom);
            if (k == 3) v = 16'h8000;
            if (k == 7) v = 16'h7FFF;
            send_item(vnos_pkg::OP_WR_VALUE, k[7:0], 8'($urandom), v,
                      24'($urandom), 24'($urandom));
        end
    endtask

    // coordinate extremes, wrap, unused code, table rewrites, reset config
    task automatic test_directed();
        send_sample(24'h000000, 24'h000000);
        send_sample(24'hFFFFFF, 24'hFFFFFF);
        send_sample(24'h00FFFF, 24'hFF0000);
        send_sample(24'hFF8000, 24'h00FFFF);
        send_item(OP_UNUSED, 8'hFF, 8'hFF, 16'hFFFF, 24'hFFFFFF, 24'hFFFFFF);
        send_sample(24'h7F0001, 24'h800000);
        send_item(vnos_pkg::OP_WR_PERM, 8'd255, 8'd0, 16'h0000, 24'h0, 24'h0);
        send_item(vnos_pkg::OP_WR_VALUE, 8'd0, 8'd255, 16'h8000, 24'h0, 24'h0);
        send_sample(24'hFF0000, 24'h000000);
        send_sample(24'h123456, 24'hABCDEF);
    endtask

    // extremes and clamped octave counts
    task automatic test_config_extremes();
        logic [15:0] p_set [6] = '{16'd1, 16'd65535, 16'd0, 16'd32768, 16'd20000, 16'd65535};
        logic [15:0] l_set [6] = '{16'd0, 16'd65535, 16'd4096, 16'd8192, 16'd12288, 16'd0};
        logic [4:0]  n_set [6] = '{5'd1, 5'd16, 5'd3, 5'd0, 5'd31, 5'd17};
        for (int s = 0; s < 6; s++) begin
            set_config(p_set[s], l_set[s], n_set[s]);
            send_sample(24'hFFFFFF, 24'h000000);
            send_sample(24'($urandom), 24'($urandom));
            send_sample(24'($urandom), 24'($urandom));
        end
    endtask

    task automatic test_random(int count);
        for (int k = 0; k < count; k++) begin
            int r;
            r = $urandom_range(99);
            if (r < 18)      send_item(vnos_pkg::OP_WR_PERM, 8'($urandom), 8'($urandom),
                                       16'($urandom), 24'($urandom), 24'($urandom));
            else if (r < 33) send_item(vnos_pkg::OP_WR_VALUE, 8'($urandom), 8'($urandom),
                                       16'($urandom), 24'($urandom), 24'($urandom));
            else if (r < 37) send_item(OP_UNUSED, 8'($urandom), 8'($urandom),
                                       16'($urandom), 24'($urandom), 24'($urandom));
            else             send_item(vnos_pkg::OP_SAMPLE, 8'($urandom), 8'($urandom),
                                       16'($urandom), 24'($urandom), 24'($urandom));
        end
    endtask

    // hold the output for a long stretch while samples keep coming
    task automatic test_backpressure();
        drain();
        hold_token++;
        repeat (6) send_sample(24'($urandom), 24'($urandom));
    endtask

    initial begin
        fail_count       = 0;
        hold_token       = 0;
        send_idle_pct    = 0;
        recv_idle_pct    = 0;
        persist_cfg      = vnos_pkg::PERSIST_RST;
        lacunar_cfg      = vnos_pkg::LACUNAR_RST;
        octaves_cfg      = vnos_pkg::OCTAVES_RST;
        i_rst_n          = 1'b0;
        i_in_valid       = 1'b0;
        i_in_operation   = vnos_pkg::OP_WR_PERM;
        i_in_table_index = '0;
        i_in_perm_entry  = '0;
        i_in_value_entry = '0;
        i_in_x_coord     = '0;
        i_in_z_coord     = '0;
        i_cfg_we         = 1'b0;
        i_cfg_idx        = vnos_pkg::CFG_PERSIST;
        i_cfg_data       = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle_pct = 27;
        recv_idle_pct = 51;
        test_table_load();
        test_directed();
        test_config_extremes();
        set_config(16'($urandom_range(65535, 1)), 16'($urandom),
                   5'($urandom_range(8, 1)));
        test_random(35);
        send_idle_pct = 51;
        recv_idle_pct = 27;
        set_config(16'($urandom_range(65535, 1)), 16'($urandom),
                   5'($urandom_range(16, 1)));
        test_random(35);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_config(16'($urandom_range(65535, 1)), 16'($urandom),
                   5'($urandom_range(6, 1)));
        test_random(35);
        test_backpressure();
        drain();

        if (fail_count == 0 && expected_heights.size() == 0)
            $display("value_noise_octave_sampler_unit: match");
        else
            $display("value_noise_octave_sampler_unit: mismatch");
        $finish;
    end

    // run limit
    initial begin
        #20000000;
        $display("value_noise_octave_sampler_unit: mismatch");
        $finish;
    end

endmodule

[files.f]
design/vnos_pkg.sv
design/value_noise_octave_sampler_unit.sv
design/vnos_checker.sv
bench/tb_value_noise_octave_sampler_unit.sv
